// ----- src/pla_pkg.sv -----
// Shared types, constants and helpers for the piecewise-linear advection block.
package pla_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CFG_WIDTH   = 16;
  localparam int WIDE_W      = 64;
  localparam int MAG_W       = 62;
  localparam int FRAC_BITS   = 16;
  localparam int FILL_W      = 3;

  typedef logic signed [WIDE_W-1:0] wide_t;

  // Intermediates saturate to +-(2^62 - 1)
  localparam wide_t WIDE_LIM     = {{(WIDE_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};
  localparam wide_t NEG_WIDE_LIM = -WIDE_LIM;
  localparam wide_t ONE_Q        = {{(WIDE_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(4);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] q_value;
    logic signed [VALUE_WIDTH-1:0] velocity;
    logic                          row_start;
    logic                          row_end;
  } pla_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] q_next;
    logic                          last;
  } pla_out_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_COUR,
    SQ_DQ_SUB,
    SQ_DQ_HALF,
    SQ_T_SUB,
    SQ_T_HALF,
    SQ_CORR,
    SQ_UP,
    SQ_FLUX,
    SQ_M1,
    SQ_DU,
    SQ_DIV,
    SQ_R1,
    SQ_R2,
    SQ_R3,
    SQ_OUT
  } seq_state_e;

  function automatic wide_t sext_value(logic [VALUE_WIDTH-1:0] v);
    return {{(WIDE_W-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
  endfunction

endpackage

// ----- src/pla_qmul.sv -----
// Multi-cycle saturating 64-bit Q48.16 multiplier built on one 32x32 partial-product multiplier.
module pla_qmul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  abs_i,
  input  pla_pkg::wide_t        a_i,
  input  pla_pkg::wide_t        b_i,
  output logic                  done_o,
  output pla_pkg::wide_t        y_o
);

  localparam int HALF_W  = 32;
  localparam int PROD_W  = 2 * HALF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int LO_W    = HALF_W - pla_pkg::FRAC_BITS;
  localparam int HI_KEEP = pla_pkg::MAG_W + pla_pkg::FRAC_BITS - PROD_W;

  localparam logic [2:0] STEP_LL  = 3'd0;
  localparam logic [2:0] STEP_LH  = 3'd1;
  localparam logic [2:0] STEP_HL  = 3'd2;
  localparam logic [2:0] STEP_HH  = 3'd3;
  localparam logic [2:0] STEP_FIN = 3'd4;

  logic                       busy_q;
  logic                       done_q;
  logic [2:0]                 step_q;
  logic                       neg_q;
  logic [pla_pkg::MAG_W-1:0]  ma_q, mb_q;
  logic [pla_pkg::MAG_W-1:0]  ma_abs, mb_abs;
  pla_pkg::wide_t             a_neg, b_neg;
  logic [ACC_W-1:0]           acc_q;
  logic [HALF_W-1:0]          mid_q;
  logic [LO_W-1:0]            lo_q;
  logic [HALF_W-1:0]          ah, bh;
  logic [PROD_W-1:0]          pp;
  logic [ACC_W-1:0]           sum;
  logic [pla_pkg::MAG_W-1:0]  res;
  pla_pkg::wide_t             res_w;
  logic                       sat;
  pla_pkg::wide_t             y_q;

  always_comb begin
    a_neg  = -a_i;
    b_neg  = -b_i;
    ma_abs = a_i[pla_pkg::WIDE_W-1] ? a_neg[pla_pkg::MAG_W-1:0] : a_i[pla_pkg::MAG_W-1:0];
    mb_abs = b_i[pla_pkg::WIDE_W-1] ? b_neg[pla_pkg::MAG_W-1:0] : b_i[pla_pkg::MAG_W-1:0];
  end

  // step bit 1 picks the high half of a, step bit 0 the high half of b
  always_comb begin
    ah    = step_q[1] ? HALF_W'(ma_q[pla_pkg::MAG_W-1:HALF_W]) : ma_q[HALF_W-1:0];
    bh    = step_q[0] ? HALF_W'(mb_q[pla_pkg::MAG_W-1:HALF_W]) : mb_q[HALF_W-1:0];
    pp    = PROD_W'(ah) * PROD_W'(bh);
    sum   = acc_q + ACC_W'(pp);
    res   = {acc_q[HI_KEEP-1:0], mid_q, lo_q};
    res_w = pla_pkg::wide_t'({{(pla_pkg::WIDE_W-pla_pkg::MAG_W){1'b0}}, res});
    sat   = |acc_q[ACC_W-1:HI_KEEP];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LL;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= STEP_LL;
      end else if (busy_q) begin
        if (step_q == STEP_FIN) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      ma_q  <= ma_abs;
      mb_q  <= mb_abs;
      neg_q <= abs_i ? 1'b0 : (a_i[pla_pkg::WIDE_W-1] ^ b_i[pla_pkg::WIDE_W-1]);
    end else if (busy_q) begin
      case (step_q)
        STEP_LL: begin
          lo_q  <= pp[HALF_W-1:pla_pkg::FRAC_BITS];
          acc_q <= ACC_W'(pp[PROD_W-1:HALF_W]);
        end
        STEP_LH: begin
          acc_q <= sum;
        end
        STEP_HL: begin
          mid_q <= sum[HALF_W-1:0];
          acc_q <= ACC_W'(sum[ACC_W-1:HALF_W]);
        end
        STEP_HH: begin
          acc_q <= sum;
        end
        STEP_FIN: begin
          if (sat) begin
            y_q <= neg_q ? pla_pkg::NEG_WIDE_LIM : pla_pkg::WIDE_LIM;
          end else begin
            y_q <= neg_q ? -res_w : res_w;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

// ----- src/piecewise_linear_advection_1d.sv -----
// Top level: 1-D upwind piecewise-linear advection over a streamed row.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+-------------------------
//   config   | cfg_we_i                      | cfg_wdata_i (dt/dx Q0.16)
//   input    | in_valid_i / in_ready_o       | in_data_i  (pla_in_t)
//   output   | out_valid_o / out_ready_i     | out_data_o (pla_out_t)
//
// A point that only fills the window is taken without leaving the idle state.
// A point that yields a result takes eight products through the one shared
// multiplier, fourteen saturating add steps and a load of the output register
// before it is offered; the next point is taken only once the sequencer is
// back in idle.
// The output register frees the sequencer while a result waits; a stall on
// the output holds the sequencer only when a second result is ready.
// Reset clears the window fill count, dt/dx, the sequencer and the output valid flag.
module piecewise_linear_advection_1d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pla_pkg::CFG_WIDTH-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pla_pkg::pla_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pla_pkg::pla_out_t                 out_data_o
);

  localparam int WW = pla_pkg::WIDE_W;
  localparam int VW = pla_pkg::VALUE_WIDTH;

  localparam logic signed [WW:0] LIM_EXT     = (WW+1)'(pla_pkg::WIDE_LIM);
  localparam logic signed [WW:0] NEG_LIM_EXT = -LIM_EXT;

  pla_pkg::seq_state_e              state_q, state_d;
  logic [pla_pkg::CFG_WIDTH-1:0]    dt_q;
  logic [pla_pkg::FILL_W-1:0]       fill_q, fill_eff, fill_d;
  logic                             win_full;
  logic                             in_acc;
  logic [VW-1:0]                    qh_q [4];
  logic [VW-1:0]                    uh_q [2];
  pla_pkg::wide_t                   qm2_q, qm1_q, q0_q, qp1_q, qp2_q, ul_q, ur_q;
  logic                             last_q;
  logic                             face_q;
  logic                             issued_q;
  pla_pkg::wide_t                   cour_q, dq_q, tmp_q, fl_q, fr_q;
  pla_pkg::wide_t                   fv, fa, fb, fc, fd;
  logic                             fneg;
  pla_pkg::wide_t                   rate_w;
  pla_pkg::wide_t                   alu_x, alu_y, alu_y_inv, alu_clamp, alu_res;
  logic                             alu_sub, alu_half;
  logic signed [WW:0]               alu_sum;
  logic                             mul_start, mul_abs, mul_done, is_mul;
  pla_pkg::wide_t                   mul_a, mul_b, mul_y;
  logic                             out_valid_q, out_load;
  pla_pkg::pla_out_t                out_q;
  logic [WW-VW:0]                   res_upper;
  logic [VW-1:0]                    res_sat;

  assign in_ready_o = (state_q == pla_pkg::SQ_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    fill_eff = in_data_i.row_start ? '0 : fill_q;
    win_full = (fill_eff == pla_pkg::FILL_FULL);
    if (in_data_i.row_end) begin
      fill_d = '0;
    end else if (win_full) begin
      fill_d = pla_pkg::FILL_FULL;
    end else begin
      fill_d = fill_eff + pla_pkg::FILL_W'(1);
    end
  end

  // stencil for the face being worked on: left face first, then right
  always_comb begin
    fv   = face_q ? ur_q  : ul_q;
    fa   = face_q ? qm1_q : qm2_q;
    fb   = face_q ? q0_q  : qm1_q;
    fc   = face_q ? qp1_q : q0_q;
    fd   = face_q ? qp2_q : qp1_q;
    fneg = fv[WW-1];
  end

  assign rate_w = pla_pkg::wide_t'({{(WW-pla_pkg::CFG_WIDTH){1'b0}}, dt_q});

  // shared saturating adder; half mode adds the sign bit then shifts (rounds toward zero)
  always_comb begin
    alu_y_inv = alu_sub ? ~alu_y : alu_y;
    alu_sum   = $signed({alu_x[WW-1], alu_x}) + $signed({alu_y_inv[WW-1], alu_y_inv})
              + $signed({{WW{1'b0}}, alu_sub});
    if (alu_sum > LIM_EXT) begin
      alu_clamp = pla_pkg::WIDE_LIM;
    end else if (alu_sum < NEG_LIM_EXT) begin
      alu_clamp = pla_pkg::NEG_WIDE_LIM;
    end else begin
      alu_clamp = alu_sum[WW-1:0];
    end
    alu_res = alu_half ? (alu_clamp >>> 1) : alu_clamp;
  end

  pla_qmul u_qmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .abs_i   (mul_abs),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .y_o     (mul_y)
  );

  // sequencer outputs
  always_comb begin
    alu_x    = '0;
    alu_y    = '0;
    alu_sub  = 1'b0;
    alu_half = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    mul_abs  = 1'b0;
    is_mul   = state_q inside {pla_pkg::SQ_COUR, pla_pkg::SQ_CORR, pla_pkg::SQ_FLUX,
                               pla_pkg::SQ_M1, pla_pkg::SQ_DIV};
    mul_start = is_mul && !issued_q;
    out_load  = (state_q == pla_pkg::SQ_OUT) && (!out_valid_q || out_ready_i);
    case (state_q)
      pla_pkg::SQ_COUR: begin
        mul_a   = fv;
        mul_b   = rate_w;
        mul_abs = 1'b1;
      end
      pla_pkg::SQ_DQ_SUB: begin
        alu_x   = fneg ? fd : fc;
        alu_y   = fneg ? fb : fa;
        alu_sub = 1'b1;
      end
      pla_pkg::SQ_DQ_HALF, pla_pkg::SQ_T_HALF: begin
        alu_x    = tmp_q;
        alu_y    = {{(WW-1){1'b0}}, tmp_q[WW-1]};
        alu_half = 1'b1;
      end
      pla_pkg::SQ_T_SUB: begin
        alu_x   = pla_pkg::ONE_Q;
        alu_y   = cour_q;
        alu_sub = 1'b1;
      end
      pla_pkg::SQ_CORR: begin
        mul_a = tmp_q;
        mul_b = dq_q;
      end
      pla_pkg::SQ_UP: begin
        if (fneg) begin
          alu_x   = tmp_q;
          alu_y   = fc;
          alu_sub = 1'b1;
        end else begin
          alu_x = fb;
          alu_y = tmp_q;
        end
      end
      pla_pkg::SQ_FLUX, pla_pkg::SQ_DIV: begin
        mul_a = cour_q;
        mul_b = tmp_q;
      end
      pla_pkg::SQ_M1: begin
        mul_a = rate_w;
        mul_b = q0_q;
      end
      pla_pkg::SQ_DU: begin
        alu_x   = ur_q;
        alu_y   = ul_q;
        alu_sub = 1'b1;
      end
      pla_pkg::SQ_R1: begin
        alu_x   = fr_q;
        alu_y   = fl_q;
        alu_sub = 1'b1;
      end
      pla_pkg::SQ_R2: begin
        alu_x   = q0_q;
        alu_y   = tmp_q;
        alu_sub = 1'b1;
      end
      pla_pkg::SQ_R3: begin
        alu_x = tmp_q;
        alu_y = dq_q;
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pla_pkg::SQ_IDLE:    if (in_acc && win_full) state_d = pla_pkg::SQ_COUR;
      pla_pkg::SQ_COUR:    if (mul_done) state_d = pla_pkg::SQ_DQ_SUB;
      pla_pkg::SQ_DQ_SUB:  state_d = pla_pkg::SQ_DQ_HALF;
      pla_pkg::SQ_DQ_HALF: state_d = pla_pkg::SQ_T_SUB;
      pla_pkg::SQ_T_SUB:   state_d = pla_pkg::SQ_T_HALF;
      pla_pkg::SQ_T_HALF:  state_d = pla_pkg::SQ_CORR;
      pla_pkg::SQ_CORR:    if (mul_done) state_d = pla_pkg::SQ_UP;
      pla_pkg::SQ_UP:      state_d = pla_pkg::SQ_FLUX;
      pla_pkg::SQ_FLUX: begin
        if (mul_done) state_d = face_q ? pla_pkg::SQ_M1 : pla_pkg::SQ_COUR;
      end
      pla_pkg::SQ_M1:      if (mul_done) state_d = pla_pkg::SQ_DU;
      pla_pkg::SQ_DU:      state_d = pla_pkg::SQ_DIV;
      pla_pkg::SQ_DIV:     if (mul_done) state_d = pla_pkg::SQ_R1;
      pla_pkg::SQ_R1:      state_d = pla_pkg::SQ_R2;
      pla_pkg::SQ_R2:      state_d = pla_pkg::SQ_R3;
      pla_pkg::SQ_R3:      state_d = pla_pkg::SQ_OUT;
      pla_pkg::SQ_OUT:     if (out_load) state_d = pla_pkg::SQ_IDLE;
      default:             state_d = pla_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pla_pkg::SQ_IDLE;
      dt_q        <= '0;
      fill_q      <= '0;
      face_q      <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dt_q <= cfg_wdata_i;
      if (in_acc) fill_q <= fill_d;
      if (in_acc) begin
        face_q <= 1'b0;
      end else if (state_q == pla_pkg::SQ_FLUX && mul_done) begin
        face_q <= 1'b1;
      end
      if (mul_start) begin
        issued_q <= 1'b1;
      end else if (mul_done) begin
        issued_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // final saturation to the value width
  always_comb begin
    res_upper = tmp_q[WW-1:VW-1];
    if ((&res_upper) || !(|res_upper)) begin
      res_sat = tmp_q[VW-1:0];
    end else begin
      res_sat = tmp_q[WW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      // window captured before the history shifts, newest point as qp2
      qm2_q   <= pla_pkg::sext_value(qh_q[3]);
      qm1_q   <= pla_pkg::sext_value(qh_q[2]);
      q0_q    <= pla_pkg::sext_value(qh_q[1]);
      qp1_q   <= pla_pkg::sext_value(qh_q[0]);
      qp2_q   <= pla_pkg::sext_value(in_data_i.q_value);
      ul_q    <= pla_pkg::sext_value(uh_q[1]);
      ur_q    <= pla_pkg::sext_value(uh_q[0]);
      last_q  <= in_data_i.row_end;
      qh_q[3] <= qh_q[2];
      qh_q[2] <= qh_q[1];
      qh_q[1] <= qh_q[0];
      qh_q[0] <= in_data_i.q_value;
      uh_q[1] <= uh_q[0];
      uh_q[0] <= in_data_i.velocity;
    end
    case (state_q)
      pla_pkg::SQ_COUR, pla_pkg::SQ_M1: if (mul_done) cour_q <= mul_y;
      pla_pkg::SQ_DQ_HALF:              dq_q <= alu_res;
      pla_pkg::SQ_DIV:                  if (mul_done) dq_q <= mul_y;
      pla_pkg::SQ_CORR:                 if (mul_done) tmp_q <= mul_y;
      pla_pkg::SQ_FLUX: begin
        if (mul_done) begin
          if (face_q) begin
            fr_q <= mul_y;
          end else begin
            fl_q <= mul_y;
          end
        end
      end
      pla_pkg::SQ_DQ_SUB, pla_pkg::SQ_T_SUB, pla_pkg::SQ_T_HALF, pla_pkg::SQ_UP,
      pla_pkg::SQ_DU, pla_pkg::SQ_R1, pla_pkg::SQ_R2, pla_pkg::SQ_R3: begin
        tmp_q <= alu_res;
      end
      pla_pkg::SQ_OUT: begin
        if (out_load) begin
          out_q.q_next <= res_sat;
          out_q.last   <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
